FILE: src/mgt_pkg.sv
// Shared types and constants for the general-purpose timer.
`timescale 1ns / 1ps

package mgt_pkg;

    // Build options
    localparam bit       BIDIRECTIONAL  = 1'b1;
    localparam bit       WIDE_COUNTER   = 1'b1;
    localparam bit [3:0] PSC_SHIFT_MASK = 4'd0;
    localparam bit       HAS_SLAVE_MODE = 1'b1;

    localparam logic [15:0] CNT_MASK = WIDE_COUNTER ? 16'hffff : 16'h00ff;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Dense register indexes
    localparam logic [3:0] REG_CR1  = 4'd0;
    localparam logic [3:0] REG_SMCR = 4'd1;
    localparam logic [3:0] REG_IER  = 4'd2;
    localparam logic [3:0] REG_SR   = 4'd3;
    localparam logic [3:0] REG_EGR  = 4'd4;
    localparam logic [3:0] REG_CNTH = 4'd5;
    localparam logic [3:0] REG_CNTL = 4'd6;
    localparam logic [3:0] REG_PSCH = 4'd7;
    localparam logic [3:0] REG_PSCL = 4'd8;
    localparam logic [3:0] REG_ARRH = 4'd9;
    localparam logic [3:0] REG_ARRL = 4'd10;

    // CR1 bits
    localparam logic [7:0] B_CEN  = 8'h01;
    localparam logic [7:0] B_UDIS = 8'h02;
    localparam logic [7:0] B_OPM  = 8'h08;
    localparam logic [7:0] B_DIR  = 8'h10;
    localparam logic [7:0] B_CMS  = 8'h60;
    // SR / IER / EGR bit 0
    localparam logic [7:0] B_UIF  = 8'h01;
    localparam logic [7:0] B_UG   = 8'h01;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_index;
        logic [7:0] write_data;
        logic       peripheral_clock_on;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        update_irq;
        logic [15:0] counter_value;
        logic        counting;
    } t_out_item;

endpackage

FILE: src/mcu_general_timer.sv
// Top level of the general-purpose timer: handshakes and result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in        input      i_in_valid/o_in_stall    i_in_item   (t_in_item)
// out       output     o_out_valid/i_out_stall  o_out_item  (t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_data  (simulation_on)
//
// One transaction per cycle while o_in_stall is low; its result is in o_out_item on the next cycle.
// The timer state is updated at the accepting edge, so back-to-back items
// see each other's effects. A held result only stalls the input while
// i_out_stall is high. Synchronous reset leaves counter 0, ARR all ones,
// simulation on; no clearing pass.

module mcu_general_timer import mgt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item core_result;
    logic      in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    mgt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (in_accept),
        .i_item       (i_in_item),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (in_accept)
            r_out_item <= core_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: src/mgt_core.sv
// Timer register file, prescaler and counter: one transaction per cycle.
`timescale 1ns / 1ps

module mgt_core import mgt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output t_out_item o_result
);

    logic        r_sim_on;
    logic [7:0]  r_cr1, r_smcr, r_ier, r_sr, r_cnt_lo_latch, r_psc_hi_hold;
    logic [15:0] r_cnt, r_psc_cnt, r_psc_pre, r_arr;

    logic [7:0]  n_cr1, n_smcr, n_ier, n_sr, n_cnt_lo_latch, n_psc_hi_hold;
    logic [15:0] n_cnt, n_psc_cnt, n_psc_pre, n_arr;
    logic [7:0]  n_rd;

    logic [15:0] arr_now;
    logic [15:0] psc_reload;
    logic [3:0]  psc_shift;
    logic [15:0] psc_dec;
    logic [2:0]  sms;
    logic        enc_mode;
    logic        upd;

    assign arr_now   = r_arr & CNT_MASK;
    assign psc_shift = r_psc_pre[3:0] & PSC_SHIFT_MASK;
    assign psc_reload = (PSC_SHIFT_MASK != 4'd0) ? ((16'd1 << psc_shift) - 16'd1) : r_psc_pre;
    assign psc_dec   = (r_psc_cnt != 16'd0) ? (r_psc_cnt - 16'd1) : 16'd0;
    assign sms       = r_smcr[2:0];
    assign enc_mode  = HAS_SLAVE_MODE && (sms inside {[3'd1:3'd3]});

    always_comb begin
        n_cr1          = r_cr1;
        n_smcr         = r_smcr;
        n_ier          = r_ier;
        n_sr           = r_sr;
        n_cnt          = r_cnt;
        n_psc_cnt      = r_psc_cnt;
        n_psc_pre      = r_psc_pre;
        n_psc_hi_hold  = r_psc_hi_hold;
        n_arr          = r_arr;
        n_cnt_lo_latch = r_cnt_lo_latch;
        n_rd           = 8'h00;
        upd            = 1'b0;

        if (i_item_valid) begin
            case (i_item.opcode)
                OP_TICK: begin
                    if (r_sim_on && i_item.peripheral_clock_on) begin
                        if (psc_dec != 16'd0) begin
                            n_psc_cnt = psc_dec;
                        end else begin
                            n_psc_cnt = psc_reload;
                            if ((r_cr1 & B_CEN) != 8'h00) begin
                                if (!(BIDIRECTIONAL && (r_cr1 & B_DIR) != 8'h00)) begin
                                    n_cnt = (r_cnt + 16'd1) & CNT_MASK;
                                    if (n_cnt == arr_now) begin
                                        if (!BIDIRECTIONAL || (r_cr1 & B_CMS) == 8'h00)
                                            n_cnt = 16'd0;
                                        else
                                            n_cr1 = n_cr1 | B_DIR;
                                        upd = (n_cr1 & B_UDIS) == 8'h00;
                                    end
                                end else begin
                                    n_cnt = (r_cnt + CNT_MASK) & CNT_MASK;
                                    if (n_cnt == 16'd0) begin
                                        if ((r_cr1 & B_CMS) == 8'h00)
                                            n_cnt = arr_now;
                                        else
                                            n_cr1 = n_cr1 & ~B_DIR;
                                        upd = (n_cr1 & B_UDIS) == 8'h00;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    case (i_item.reg_index)
                        REG_CR1:  n_rd = r_cr1;
                        REG_SMCR: n_rd = HAS_SLAVE_MODE ? r_smcr : 8'h00;
                        REG_IER:  n_rd = r_ier;
                        REG_SR:   n_rd = r_sr;
                        REG_CNTH: begin
                            if (WIDE_COUNTER) begin
                                n_cnt_lo_latch = r_cnt[7:0];
                                n_rd           = r_cnt[15:8];
                            end
                        end
                        REG_CNTL: n_rd = WIDE_COUNTER ? r_cnt_lo_latch : r_cnt[7:0];
                        REG_PSCH: n_rd = (PSC_SHIFT_MASK == 4'd0) ? r_psc_pre[15:8] : 8'h00;
                        REG_PSCL: n_rd = r_psc_pre[7:0];
                        REG_ARRH: n_rd = WIDE_COUNTER ? r_arr[15:8] : 8'h00;
                        REG_ARRL: n_rd = r_arr[7:0];
                        default:  n_rd = 8'h00;
                    endcase
                end
                OP_WRITE: begin
                    case (i_item.reg_index)
                        REG_CR1: begin
                            // DIR is read-only in center-aligned and encoder modes
                            if (BIDIRECTIONAL && ((r_cr1 & B_CMS) != 8'h00 || enc_mode))
                                n_cr1 = (i_item.write_data & ~B_DIR) | (r_cr1 & B_DIR);
                            else
                                n_cr1 = i_item.write_data;
                        end
                        REG_SMCR: if (HAS_SLAVE_MODE) n_smcr = i_item.write_data;
                        REG_IER:  n_ier = i_item.write_data;
                        REG_SR:   n_sr  = i_item.write_data;
                        REG_EGR: begin
                            if ((i_item.write_data & B_UG) != 8'h00) begin
                                upd       = 1'b1;
                                n_psc_cnt = psc_reload;
                            end
                        end
                        REG_PSCH: if (PSC_SHIFT_MASK == 4'd0) n_psc_hi_hold = i_item.write_data;
                        REG_PSCL: begin
                            if (PSC_SHIFT_MASK == 4'd0)
                                n_psc_pre = {r_psc_hi_hold, i_item.write_data};
                            else
                                n_psc_pre = {8'h00, i_item.write_data};
                        end
                        REG_ARRH: if (WIDE_COUNTER) n_arr = {i_item.write_data, r_arr[7:0]};
                        REG_ARRL: n_arr = {r_arr[15:8], i_item.write_data};
                        default: ;
                    endcase
                end
                default: ;
            endcase

            // Update event, evaluated against CR1 as left by the step above
            if (upd) begin
                if ((n_cr1 & B_OPM) != 8'h00)
                    n_cr1 = n_cr1 & ~B_CEN;
                else if (!(BIDIRECTIONAL && (n_cr1 & B_DIR) != 8'h00))
                    n_cnt = 16'd0;
                else
                    n_cnt = arr_now;
                n_sr = n_sr | B_UIF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sim_on       <= 1'b1;
            r_cr1          <= 8'h00;
            r_smcr         <= 8'h00;
            r_ier          <= 8'h00;
            r_sr           <= 8'h00;
            r_cnt          <= 16'd0;
            r_psc_cnt      <= 16'd0;
            r_psc_pre      <= 16'd0;
            r_psc_hi_hold  <= 8'h00;
            r_arr          <= CNT_MASK;
            r_cnt_lo_latch <= 8'h00;
        end else begin
            if (i_cfg_we)
                r_sim_on <= i_cfg_data;
            r_cr1          <= n_cr1;
            r_smcr         <= n_smcr;
            r_ier          <= n_ier;
            r_sr           <= n_sr;
            r_cnt          <= n_cnt;
            r_psc_cnt      <= n_psc_cnt;
            r_psc_pre      <= n_psc_pre;
            r_psc_hi_hold  <= n_psc_hi_hold;
            r_arr          <= n_arr;
            r_cnt_lo_latch <= n_cnt_lo_latch;
        end
    end

    assign o_result.read_data     = n_rd;
    assign o_result.update_irq    = n_sr[0] & n_ier[0];
    assign o_result.counter_value = n_cnt;
    assign o_result.counting      = n_cr1[0];

endmodule

FILE: tb/sv/mcu_general_timer_tb.sv
// Testbench for the general-purpose timer: directed table, random scenarios, readout checks.
`timescale 1ns / 1ps

module mcu_general_timer_tb;
    import mgt_pkg::*;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned HOLD_CYCLES  = 40;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam logic [1:0]  OP_NOP       = 2'd3;
    localparam logic [3:0]  REG_UNUSED   = 4'd15;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    bit          idling = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned errors = 0;
    int unsigned random_sent = 0;

    t_out_item awaited_readouts[$];

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_row;
    t_row plan[$];

    // Timer state as predicted
    bit          sim_on;
    logic [7:0]  cr1, smcr, ier, sr, psc_hi, cnt_lo_latch;
    logic [15:0] cnt, psc_cnt, psc_pre, arr;

    mcu_general_timer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic bit counting_down();
        return BIDIRECTIONAL && ((cr1 & B_DIR) != 0);
    endfunction

    function automatic logic [15:0] psc_reload();
        if (PSC_SHIFT_MASK != 0)
            return 16'((32'd1 << (psc_pre[3:0] & PSC_SHIFT_MASK)) - 32'd1);
        return psc_pre;
    endfunction

    function automatic void fire_update();
        if ((cr1 & B_OPM) != 0)
            cr1 = cr1 & ~B_CEN;
        else if (!counting_down())
            cnt = '0;
        else
            cnt = arr & CNT_MASK;
        sr = sr | B_UIF;
    endfunction

    function automatic void prescaled_tick();
        if (psc_cnt != 0)
            psc_cnt = psc_cnt - 16'd1;
        if (psc_cnt != 0)
            return;
        psc_cnt = psc_reload();
        if ((cr1 & B_CEN) == 0)
            return;
        if (!counting_down()) begin
            cnt = 16'(cnt + 16'd1) & CNT_MASK;
            if (cnt == (arr & CNT_MASK)) begin
                if (!BIDIRECTIONAL || (cr1 & B_CMS) == 0)
                    cnt = '0;
                else
                    cr1 = cr1 | B_DIR;
                if ((cr1 & B_UDIS) == 0)
                    fire_update();
            end
        end else begin
            cnt = 16'(cnt + CNT_MASK) & CNT_MASK;
            if (cnt == 0) begin
                if ((cr1 & B_CMS) == 0)
                    cnt = arr & CNT_MASK;
                else
                    cr1 = cr1 & ~B_DIR;
                if ((cr1 & B_UDIS) == 0)
                    fire_update();
            end
        end
    endfunction

    function automatic logic [7:0] read_reg(logic [3:0] idx);
        case (idx)
            REG_CR1:  return cr1;
            REG_SMCR: return HAS_SLAVE_MODE ? smcr : 8'h00;
            REG_IER:  return ier;
            REG_SR:   return sr;
            REG_CNTH: begin
                if (!WIDE_COUNTER)
                    return 8'h00;
                cnt_lo_latch = cnt[7:0];
                return cnt[15:8];
            end
            REG_CNTL: return WIDE_COUNTER ? cnt_lo_latch : cnt[7:0];
            REG_PSCH: return (PSC_SHIFT_MASK == 0) ? psc_pre[15:8] : 8'h00;
            REG_PSCL: return psc_pre[7:0];
            REG_ARRH: return WIDE_COUNTER ? arr[15:8] : 8'h00;
            REG_ARRL: return arr[7:0];
            default:  return 8'h00;
        endcase
    endfunction

    function automatic void write_reg(logic [3:0] idx, logic [7:0] data);
        logic [7:0] v;
        bit         encoder;
        v = data;
        case (idx)
            REG_CR1: begin
                // DIR is read-only in center-aligned and encoder modes
                encoder = HAS_SLAVE_MODE && smcr[2:0] >= 3'd1 && smcr[2:0] <= 3'd3;
                if (BIDIRECTIONAL && ((cr1 & B_CMS) != 0 || encoder))
                    v = (v & ~B_DIR) | (cr1 & B_DIR);
                cr1 = v;
            end
            REG_SMCR: if (HAS_SLAVE_MODE) smcr = v;
            REG_IER:  ier = v;
            REG_SR:   sr = v;
            REG_EGR: begin
                if ((v & B_UG) != 0) begin
                    fire_update();
                    psc_cnt = psc_reload();
                end
            end
            REG_PSCH: if (PSC_SHIFT_MASK == 0) psc_hi = v;
            REG_PSCL: psc_pre = (PSC_SHIFT_MASK == 0) ? {psc_hi, v} : {8'h00, v};
            REG_ARRH: if (WIDE_COUNTER) arr[15:8] = v;
            REG_ARRL: arr[7:0] = v;
            default: ;
        endcase
    endfunction

    function automatic t_out_item predict_readout(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.opcode)
            OP_TICK:  if (sim_on && it.peripheral_clock_on) prescaled_tick();
            OP_READ:  r.read_data = read_reg(it.reg_index);
            OP_WRITE: write_reg(it.reg_index, it.write_data);
            default: ;
        endcase
        r.update_irq    = sr[0] & ier[0];
        r.counter_value = cnt;
        r.counting      = cr1[0];
        return r;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [3:0] idx, logic [7:0] data,
                                    logic clk_on, bit typed, logic [7:0] rd);
        t_row row;
        row.stim.opcode              = op;
        row.stim.reg_index           = idx;
        row.stim.write_data          = data;
        row.stim.peripheral_clock_on = clk_on;
        row.typed                    = typed;
        row.want                     = '0;
        row.want.read_data           = rd;
        plan.push_back(row);
    endfunction

    // One transaction on the input channel; the expectation is queued at acceptance
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        t_out_item   readout;
        int unsigned gap;
        gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_stall);
        readout = predict_readout(it);
        awaited_readouts.push_back(typed ? want : readout);
    endtask

    task automatic send(logic [1:0] op, logic [3:0] idx, logic [7:0] data, logic clk_on);
        t_in_item it;
        it.opcode              = op;
        it.reg_index           = idx;
        it.write_data          = data;
        it.peripheral_clock_on = clk_on;
        send_item(it, 1'b0, '0);
        random_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_readouts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_simulation(bit on);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = on;
        do @(posedge clk); while (!cfg_ready);
        sim_on = on;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Program a small period and let the counter run through several update events
    task automatic counting_scenario();
        int unsigned n_ticks;
        logic [3:0]  idx;
        send(OP_WRITE, REG_PSCH,
             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00, 1'b1);
        send(OP_WRITE, REG_PSCL,
             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 2)), 1'b1);
        send(OP_WRITE, REG_ARRH,
             ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00, 1'b1);
        send(OP_WRITE, REG_ARRL, 8'($urandom_range(0, 15)), 1'b1);
        send(OP_WRITE, REG_SMCR,
             ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h00, 1'b1);
        send(OP_WRITE, REG_IER, 8'($urandom_range(0, 255)), 1'b1);
        send(OP_WRITE, REG_CR1,
             8'($urandom_range(0, 255)) | (($urandom_range(0, 9) != 0) ? B_CEN : 8'h00),
             1'b1);
        // UG also reloads the prescaler, so a long prescale from earlier cannot linger
        send(OP_WRITE, REG_EGR,
             8'($urandom_range(0, 255)) | (($urandom_range(0, 4) != 0) ? B_UG : 8'h00),
             1'b1);
        if ($urandom_range(0, 1) == 0)
            send(OP_WRITE, REG_SR, 8'h00, 1'b1);
        n_ticks = $urandom_range(10, 50);
        repeat (n_ticks) begin
            if ($urandom_range(0, 99) < 85) begin
                send(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 9) != 0);
            end else if ($urandom_range(0, 1) == 0) begin
                send(OP_READ, REG_CNTH, 8'($urandom_range(0, 255)), 1'b1);
                send(OP_READ, REG_CNTL, 8'($urandom_range(0, 255)), 1'b1);
            end else if ($urandom_range(0, 3) == 0) begin
                send(OP_WRITE, REG_SR, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                idx = 4'($urandom_range(0, 15));
                send(OP_READ, idx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_random(int unsigned upto);
        int unsigned n;
        while (random_sent < upto) begin
            if ($urandom_range(0, 3) != 0) begin
                counting_scenario();
            end else begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    // Result checker
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (awaited_readouts.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got %p", $time, out_item);
            end else begin
                want = awaited_readouts.pop_front();
                if (out_item.read_data !== want.read_data)
                    flag_mismatch("read_data", want.read_data, out_item.read_data);
                if (out_item.update_irq !== want.update_irq)
                    flag_mismatch("update_irq", want.update_irq, out_item.update_irq);
                if (out_item.counter_value !== want.counter_value)
                    flag_mismatch("counter_value", want.counter_value, out_item.counter_value);
                if (out_item.counting !== want.counting)
                    flag_mismatch("counting", want.counting, out_item.counting);
            end
        end
    end

    // Receiver back-pressure: short random bursts, plus one long hold-off on request
    initial begin : out_backpressure
        int unsigned n;
        bit          hold_taken;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end else if (idling && rst_n && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;

        sim_on       = 1'b1;
        cr1          = '0;
        smcr         = '0;
        ier          = '0;
        sr           = '0;
        cnt          = '0;
        psc_cnt      = '0;
        psc_pre      = '0;
        psc_hi       = '0;
        arr          = CNT_MASK;
        cnt_lo_latch = '0;
        // the model mirrors reset with an update event, then clears the flag it set
        fire_update();
        sr = sr & ~B_UIF;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_simulation(1'b1);

        // Values straight out of reset, ignored writes, unknown codes
        add_row(OP_READ,  REG_CR1,    8'h00, 1'b1, 1'b1, 8'h00);
        add_row(OP_READ,  REG_ARRH,   8'hff, 1'b0, 1'b1, 8'hff);
        add_row(OP_READ,  REG_ARRL,   8'h00, 1'b1, 1'b1, 8'hff);
        add_row(OP_READ,  REG_UNUSED, 8'hff, 1'b1, 1'b1, 8'h00);
        add_row(OP_NOP,   REG_ARRL,   8'hff, 1'b1, 1'b1, 8'h00);
        add_row(OP_WRITE, REG_UNUSED, 8'hff, 1'b1, 1'b1, 8'h00);
        add_row(OP_WRITE, REG_CNTH,   8'hff, 1'b0, 1'b1, 8'h00);
        add_row(OP_WRITE, REG_CNTL,   8'hff, 1'b1, 1'b1, 8'h00);
        add_row(OP_READ,  REG_CNTH,   8'h00, 1'b1, 1'b1, 8'h00);
        // Short period, prescaler reload of one (no division), forced update, then count through a wrap
        add_row(OP_WRITE, REG_ARRH,   8'h00, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_ARRL,   8'h02, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_PSCL,   8'h01, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_IER,    8'hff, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_EGR,    8'hff, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_CR1,    B_CEN, 1'b1, 1'b0, 8'h00);
        repeat (4)
            add_row(OP_TICK, REG_CR1, 8'h00, 1'b1, 1'b0, 8'h00);
        add_row(OP_TICK,  REG_CR1,    8'h00, 1'b0, 1'b0, 8'h00);
        // Encoder mode locks DIR; one-pulse mode drops CEN at the update
        add_row(OP_WRITE, REG_SMCR,   8'h01, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_CR1,    B_OPM | B_DIR | B_CEN, 1'b1, 1'b0, 8'h00);
        repeat (2)
            add_row(OP_TICK, REG_CR1, 8'h00, 1'b1, 1'b0, 8'h00);
        add_row(OP_WRITE, REG_SR,     8'h00, 1'b1, 1'b0, 8'h00);
        add_row(OP_READ,  REG_SR,     8'h00, 1'b1, 1'b0, 8'h00);
        foreach (plan[i])
            send_item(plan[i].stim, plan[i].typed, plan[i].want);

        run_random(300);
        // long receiver hold-off while transactions keep coming
        hold_req = 1'b1;
        run_random(600);
        settle();

        set_simulation(1'b0);
        run_random(900);
        set_simulation(1'b1);
        run_random(1400);

        idling = 1'b0;
        run_random(RANDOM_ITEMS);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
